@@ sv/tmtw_pkg.sv @@
`default_nettype none

package tmtw_pkg;

   // default screen geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // field widths of the item formats
   localparam int OP_W        = 2;
   localparam int CHAR_W      = 8;
   localparam int INDEX_W     = 11;
   localparam int COL_OUT_W   = 7;
   localparam int ROW_OUT_W   = 5;
   localparam int CELL_W      = 16;
   localparam int COLOR_W     = 8;

   // item kinds
   localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   // character and color constants
   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

   // one result item, last field in the lowest bits
   typedef struct packed {
      logic                 scrolled;
      logic [CELL_W-1:0]    cell_value;
      logic [ROW_OUT_W-1:0] cursor_row;
      logic [COL_OUT_W-1:0] cursor_column;
   } result_type;

endpackage

`default_nettype wire

@@ sv/text_mode_terminal_writer.sv @@
// channel  direction  ports                         payload (low bit up)
// req      in         req_tvalid/tready/tdata/tuser tuser: op; tdata: char_code, cell_index
// rsp      out        rsp_tvalid/tready/tdata       cursor_column, cursor_row, cell_value,
//                                                   scrolled
// csr      in         csr_wr_en/csr_wr_data         text_color
//
// After reset all ROWS*COLUMNS cells (2000 by default) of the store are blanked one cell a
// cycle with req_tready low; csr writes are taken meanwhile.
// A put on the same row, a delete at the top-left cell, a read past the store or an unused
// op passes the execute and done steps; a wrapping put, newline or other op adds a next-row,
// blank or read-wait step. A scroll adds a row-copy walk of the store after the next-row step.
// A full output register with rsp_tready low holds the sequencer in its final step.
`default_nettype none

module text_mode_terminal_writer
   import tmtw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [23:0]        req_tdata,  // char_code[7:0], cell_index[18:8]
   input  wire logic [OP_W-1:0]    req_tuser,  // op
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [31:0]             rsp_tdata,  // cursor_column[6:0], cursor_row[11:7],
                                               // cell_value[27:12], scrolled[28]
   input  wire logic               csr_wr_en,
   input  wire logic [COLOR_W-1:0] csr_wr_data
);

   logic [COLOR_W-1:0] text_color_ff;
   logic               rsp_valid_ff;
   result_type         rsp_data_ff;
   logic               res_valid;
   logic               res_ready;
   result_type         res_data;

   tmtw_core #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser),
      .req_char   (req_tdata[CHAR_W-1:0]),
      .req_index  (req_tdata[CHAR_W+INDEX_W-1:CHAR_W]),
      .text_color (text_color_ff),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_data   (res_data)
   );

   // color register
   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= RESET_COLOR;
      end else if (csr_wr_en) begin
         text_color_ff <= csr_wr_data;
      end
   end

   // output register for the result item
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule

`default_nettype wire

@@ sv/tmtw_alu.sv @@
`default_nettype none

module tmtw_alu
   import tmtw_pkg::*;
#(
   parameter int WIDTH = 12
) (
   input  wire logic [WIDTH-1:0] a,
   input  wire logic [WIDTH-1:0] b,
   input  wire logic             sub,
   output logic      [WIDTH-1:0] sum
);

   // shared address adder: a plus or minus b
   always_comb begin
      if (sub) begin
         sum = a - b;
      end else begin
         sum = a + b;
      end
   end

endmodule

`default_nettype wire

@@ sv/tmtw_core.sv @@
`default_nettype none

module tmtw_core
   import tmtw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [OP_W-1:0]    req_op,
   input  wire logic [CHAR_W-1:0]  req_char,
   input  wire logic [INDEX_W-1:0] req_index,
   input  wire logic [COLOR_W-1:0] text_color,
   output logic                    res_valid,
   input  wire logic               res_ready,
   output result_type              res_data
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int AW = $clog2(CELL_COUNT);
   localparam int SW = AW + 1;
   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(ROWS);
   localparam int IW = (SW > INDEX_W) ? SW : INDEX_W;

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_EXEC    = 3'd2;
   localparam logic [2:0] ST_NEXTROW = 3'd3;
   localparam logic [2:0] ST_BLANK   = 3'd4;
   localparam logic [2:0] ST_RDWAIT  = 3'd5;
   localparam logic [2:0] ST_SCROLL  = 3'd6;
   localparam logic [2:0] ST_DONE    = 3'd7;

   localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [SW-1:0]      ptr_ff, ptr_in;
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic               pend_ff, pend_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [CELL_W-1:0]  val_ff, val_in;
   logic               scrolled_ff, scrolled_in;

   logic [CELL_W-1:0]  mem [CELL_COUNT];
   logic [CELL_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [CELL_W-1:0]  mem_wdata;
   logic [AW-1:0]      mem_raddr;

   logic [SW-1:0]      alu_a;
   logic [SW-1:0]      alu_b;
   logic               alu_sub;
   logic [SW-1:0]      alu_sum;

   // the shared adder for address steps; the scroll write pointer has its own increment
   tmtw_alu #(
      .WIDTH (SW)
   ) u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .sub (alu_sub),
      .sum (alu_sum)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   // result fields
   always_comb begin
      res_data.cursor_column = COL_OUT_W'(col_ff);
      res_data.cursor_row    = ROW_OUT_W'(row_ff);
      res_data.cell_value    = val_ff;
      res_data.scrolled      = scrolled_ff;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      base_in     = base_ff;
      ptr_in      = ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      pend_in     = pend_ff;
      op_in       = op_ff;
      char_in     = char_ff;
      idx_in      = idx_ff;
      val_in      = val_ff;
      scrolled_in = scrolled_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;
      mem_raddr   = '0;
      alu_a       = SW'(base_ff);
      alu_b       = SW'(col_ff);
      alu_sub     = 1'b0;

      unique case (state_ff)
         // blank the whole store after reset
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AW-1:0];
            mem_wdata = {RESET_COLOR, BLANK_CODE};
            alu_a     = ptr_ff;
            alu_b     = SW'(1);
            ptr_in    = alu_sum;
            if (ptr_ff == SW'(CELL_COUNT - 1)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_op;
               char_in     = req_char;
               idx_in      = req_index;
               val_in      = '0;
               scrolled_in = 1'b0;
               state_in    = ST_EXEC;
            end
         end

         ST_EXEC: begin
            case (op_ff)
               OP_PUT: begin
                  if (char_ff == NEWLINE_CODE) begin
                     col_in   = '0;
                     state_in = ST_NEXTROW;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = alu_sum[AW-1:0];
                     mem_wdata = {text_color, char_ff};
                     if (col_ff == LAST_COL) begin
                        col_in   = '0;
                        state_in = ST_NEXTROW;
                     end else begin
                        col_in   = col_ff + CW'(1);
                        state_in = ST_DONE;
                     end
                  end
               end
               OP_DELETE: begin
                  if (col_ff == '0 && row_ff == '0) begin
                     state_in = ST_DONE;
                  end else if (col_ff != '0) begin
                     col_in   = col_ff - CW'(1);
                     state_in = ST_BLANK;
                  end else begin
                     // step back over the row start
                     alu_b    = SW'(COLUMNS);
                     alu_sub  = 1'b1;
                     base_in  = alu_sum[AW-1:0];
                     row_in   = row_ff - RW'(1);
                     col_in   = LAST_COL;
                     state_in = ST_BLANK;
                  end
               end
               OP_READ: begin
                  if (IW'(idx_ff) < IW'(CELL_COUNT)) begin
                     mem_raddr = AW'(idx_ff);
                     state_in  = ST_RDWAIT;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         // move to the next row or start a scroll
         ST_NEXTROW: begin
            if (row_ff == LAST_ROW) begin
               ptr_in      = SW'(COLUMNS);
               wr_ptr_in   = '0;
               pend_in     = 1'b0;
               scrolled_in = 1'b1;
               state_in    = ST_SCROLL;
            end else begin
               alu_b    = SW'(COLUMNS);
               base_in  = alu_sum[AW-1:0];
               row_in   = row_ff + RW'(1);
               state_in = ST_DONE;
            end
         end

         ST_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = alu_sum[AW-1:0];
            mem_wdata = {text_color, BLANK_CODE};
            state_in  = ST_DONE;
         end

         ST_RDWAIT: begin
            val_in   = rd_data_ff;
            state_in = ST_DONE;
         end

         // row copy walk: read one row ahead, write one cell behind, then blank the last row
         ST_SCROLL: begin
            alu_a = ptr_ff;
            alu_b = SW'(1);
            if (ptr_ff < SW'(CELL_COUNT)) begin
               mem_raddr = ptr_ff[AW-1:0];
               ptr_in    = alu_sum;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_ptr_ff;
               mem_wdata = rd_data_ff;
               wr_ptr_in = wr_ptr_ff + AW'(1);
            end else if (wr_ptr_ff >= AW'(CELL_COUNT - COLUMNS)) begin
               mem_we    = 1'b1;
               mem_waddr = wr_ptr_ff;
               mem_wdata = {text_color, BLANK_CODE};
               wr_ptr_in = wr_ptr_ff + AW'(1);
               if (wr_ptr_ff == AW'(CELL_COUNT - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         col_ff      <= '0;
         row_ff      <= '0;
         base_ff     <= '0;
         ptr_ff      <= '0;
         wr_ptr_ff   <= '0;
         pend_ff     <= 1'b0;
         scrolled_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         base_ff     <= base_in;
         ptr_ff      <= ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         pend_ff     <= pend_in;
         scrolled_ff <= scrolled_in;
      end
   end

   // item payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      char_ff <= char_in;
      idx_ff  <= idx_in;
      val_ff  <= val_in;
   end

   // cell store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

endmodule

`default_nettype wire
